@@ src/urp_pkg.sv @@
// ----------------------------------------------------------------------------
// urp_pkg: shared types and constants for the record stream parser
// Parse phases, field kinds, compact-size prefix bytes and the result
// bundle passed from the parser core to the output stage.
// ----------------------------------------------------------------------------
package urp_pkg;

  // Compact-size prefix bytes.
  localparam logic [7:0] CS_PREFIX16 = 8'hFD;
  localparam logic [7:0] CS_PREFIX32 = 8'hFE;
  localparam logic [7:0] CS_PREFIX64 = 8'hFF;

  // Prefix payload sizes in bytes.
  localparam logic [3:0] CS_SIZE16 = 4'd2;
  localparam logic [3:0] CS_SIZE32 = 4'd4;
  localparam logic [3:0] CS_SIZE64 = 4'd8;

  // Fixed field sizes in bytes.
  localparam logic [3:0]  HEIGHT_BYTES = 4'd4;
  localparam logic [3:0]  VOUT_BYTES   = 4'd4;
  localparam logic [3:0]  VALUE_BYTES  = 4'd8;
  localparam logic [31:0] HASH_BYTES   = 32'd32;

  // Parse phases. Codes above PH_DONE take the overrun branch like PH_DONE.
  typedef enum logic [3:0] {
    PH_CNT0   = 4'd0,
    PH_CNTX   = 4'd1,
    PH_HEIGHT = 4'd2,
    PH_HASH   = 4'd3,
    PH_VOUT   = 4'd4,
    PH_VALUE  = 4'd5,
    PH_LEN0   = 4'd6,
    PH_LENX   = 4'd7,
    PH_SCRIPT = 4'd8,
    PH_DONE   = 4'd9
  } phase_t;

  // Kind of field carried by a result word.
  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_HEIGHT      = 3'd1,
    KIND_HASH_BYTE   = 3'd2,
    KIND_VOUT        = 3'd3,
    KIND_VALUE       = 3'd4,
    KIND_SCRIPT_LEN  = 3'd5,
    KIND_SCRIPT_BYTE = 3'd6
  } kind_t;

  // One result word.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [15:0] index;
    logic        done;
    logic        import_end;
    logic        import_ok;
  } urp_result_t;

endpackage

@@ src/urp_core.sv @@
// ----------------------------------------------------------------------------
// urp_core: byte-level parse state machine
// Holds the parse state and, for the byte presented with step, computes the
// result word it causes and the state after it, combinationally.
// ----------------------------------------------------------------------------
module urp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 res_valid,
  output urp_pkg::urp_result_t res
);
  import urp_pkg::*;

  // Parse state.
  phase_t      phase_r,       phase_nxt;
  logic [3:0]  cnt_r,         cnt_nxt;
  logic [63:0] shift_r,       shift_nxt;
  logic [15:0] left_r,        left_nxt;
  logic [15:0] recnum_r,      recnum_nxt;
  logic [31:0] script_left_r, script_left_nxt;
  logic [3:0]  prefix_r,      prefix_nxt;
  logic        overrun_r,     overrun_nxt;

  // Byte accumulation helpers.
  logic [63:0] shift_take;
  logic [3:0]  cnt_take;
  logic [15:0] left_dec;
  logic [31:0] script_dec;
  logic [31:0] len_value;

  kind_t       kind;
  logic [63:0] value;
  logic        done;

  assign shift_take = shift_r | ({56'd0, data_byte} << {cnt_r[2:0], 3'b000});
  assign cnt_take   = cnt_r + 4'd1;
  assign left_dec   = left_r - 16'd1;
  assign script_dec = script_left_r - 32'd1;

  // Script length as it stands once this byte is taken.
  always_comb begin
    if (phase_r == PH_LENX) begin
      len_value = shift_take[31:0];
    end else begin
      len_value = {24'd0, data_byte};
    end
  end

  // Next state and emitted field for the current byte.
  always_comb begin
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    shift_nxt       = shift_r;
    left_nxt        = left_r;
    recnum_nxt      = recnum_r;
    script_left_nxt = script_left_r;
    prefix_nxt      = prefix_r;
    overrun_nxt     = overrun_r;
    kind            = KIND_NONE;
    value           = 64'd0;
    done            = 1'b0;

    case (phase_r)
      PH_CNT0: begin
        if (data_byte == CS_PREFIX16) begin
          prefix_nxt = CS_SIZE16;
          cnt_nxt    = 4'd0;
          shift_nxt  = 64'd0;
          phase_nxt  = PH_CNTX;
        end else begin
          left_nxt   = {8'd0, data_byte};
          recnum_nxt = 16'd0;
          cnt_nxt    = 4'd0;
          shift_nxt  = 64'd0;
          phase_nxt  = (data_byte != 8'd0) ? PH_HEIGHT : PH_DONE;
        end
      end
      PH_CNTX: begin
        cnt_nxt   = cnt_take;
        shift_nxt = shift_take;
        if (cnt_take >= prefix_r) begin
          left_nxt   = shift_take[15:0];
          recnum_nxt = 16'd0;
          cnt_nxt    = 4'd0;
          shift_nxt  = 64'd0;
          phase_nxt  = (shift_take[15:0] != 16'd0) ? PH_HEIGHT : PH_DONE;
        end
      end
      PH_HEIGHT: begin
        cnt_nxt   = cnt_take;
        shift_nxt = shift_take;
        if (cnt_take >= HEIGHT_BYTES) begin
          kind            = KIND_HEIGHT;
          value           = shift_take;
          cnt_nxt         = 4'd0;
          shift_nxt       = 64'd0;
          script_left_nxt = HASH_BYTES;
          phase_nxt       = PH_HASH;
        end
      end
      PH_HASH: begin
        kind            = KIND_HASH_BYTE;
        value           = {56'd0, data_byte};
        script_left_nxt = script_dec;
        if (script_dec == 32'd0) begin
          cnt_nxt   = 4'd0;
          shift_nxt = 64'd0;
          phase_nxt = PH_VOUT;
        end
      end
      PH_VOUT: begin
        cnt_nxt   = cnt_take;
        shift_nxt = shift_take;
        if (cnt_take >= VOUT_BYTES) begin
          kind      = KIND_VOUT;
          value     = shift_take;
          cnt_nxt   = 4'd0;
          shift_nxt = 64'd0;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        cnt_nxt   = cnt_take;
        shift_nxt = shift_take;
        if (cnt_take >= VALUE_BYTES) begin
          kind      = KIND_VALUE;
          value     = shift_take;
          cnt_nxt   = 4'd0;
          shift_nxt = 64'd0;
          phase_nxt = PH_LEN0;
        end
      end
      PH_LEN0, PH_LENX: begin
        if (phase_r == PH_LEN0 && data_byte >= CS_PREFIX16) begin
          // Long length prefix: collect 2, 4 or 8 more bytes.
          case (data_byte)
            CS_PREFIX16: prefix_nxt = CS_SIZE16;
            CS_PREFIX32: prefix_nxt = CS_SIZE32;
            default:     prefix_nxt = CS_SIZE64;
          endcase
          cnt_nxt   = 4'd0;
          shift_nxt = 64'd0;
          phase_nxt = PH_LENX;
        end else if (phase_r == PH_LEN0 || cnt_take >= prefix_r) begin
          // Script length complete; an empty script closes the record.
          kind            = KIND_SCRIPT_LEN;
          value           = {32'd0, len_value};
          script_left_nxt = len_value;
          cnt_nxt         = 4'd0;
          shift_nxt       = 64'd0;
          if (len_value == 32'd0) begin
            done       = 1'b1;
            recnum_nxt = recnum_r + 16'd1;
            left_nxt   = left_dec;
            phase_nxt  = (left_dec != 16'd0) ? PH_HEIGHT : PH_DONE;
          end else begin
            phase_nxt = PH_SCRIPT;
          end
        end else begin
          cnt_nxt   = cnt_take;
          shift_nxt = shift_take;
        end
      end
      PH_SCRIPT: begin
        kind            = KIND_SCRIPT_BYTE;
        value           = {56'd0, data_byte};
        script_left_nxt = script_dec;
        if (script_dec == 32'd0) begin
          done       = 1'b1;
          recnum_nxt = recnum_r + 16'd1;
          left_nxt   = left_dec;
          cnt_nxt    = 4'd0;
          shift_nxt  = 64'd0;
          phase_nxt  = (left_dec != 16'd0) ? PH_HEIGHT : PH_DONE;
        end
      end
      default: begin
        // Bytes past the end of the list mark the import as failed.
        overrun_nxt = 1'b1;
      end
    endcase
  end

  // Result word for the current byte.
  always_comb begin
    res_valid      = last_byte || (kind != KIND_NONE);
    res.kind       = kind;
    res.value      = value;
    res.index      = (kind != KIND_NONE) ? recnum_r : 16'd0;
    res.done       = done;
    res.import_end = last_byte;
    res.import_ok  = last_byte && (phase_nxt == PH_DONE) && !overrun_nxt;
  end

  // State registers; the last byte of an import restarts the parser.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r       <= PH_CNT0;
      cnt_r         <= 4'd0;
      shift_r       <= 64'd0;
      left_r        <= 16'd0;
      recnum_r      <= 16'd0;
      script_left_r <= 32'd0;
      prefix_r      <= 4'd0;
      overrun_r     <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      shift_r       <= shift_nxt;
      left_r        <= left_nxt;
      recnum_r      <= recnum_nxt;
      script_left_r <= script_left_nxt;
      prefix_r      <= prefix_nxt;
      overrun_r     <= overrun_nxt;
    end
  end

endmodule

@@ src/utxo_record_stream_parser.sv @@
// ----------------------------------------------------------------------------
// utxo_record_stream_parser: streaming parser for serialized output records
// Decodes a record count and its records, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data_byte, in_last_byte) carries
// one byte of the serialized record list per word; in_last_byte marks the
// final byte of an import. The result channel (out_valid, out_stall, out_*)
// carries one word for each completed field (height, hash byte, vout, value,
// script length, script byte) and one word for every last byte, which
// reports in out_import_ok whether the list ended exactly on that byte.
// Bytes that complete no field and are not last give no result word.
// A result appears in the cycle after its byte is accepted. Throughput is
// one byte per cycle unless a held result stalls; the parse state and the
// output register update in the same cycle, so bytes may arrive back to back.
// While the receiver stalls a held result, in_stall follows out_stall and no
// byte is taken; an empty or draining output register never blocks input.
// Reset (rst_n low, synchronous) empties the output register and returns the
// parser to the count phase; accepting a last byte also restarts the parser.
// ----------------------------------------------------------------------------
module utxo_record_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_field_kind,
  output logic [63:0] out_field_value,
  output logic [15:0] out_record_index,
  output logic        out_record_done,
  output logic        out_import_end,
  output logic        out_import_ok
);
  import urp_pkg::*;

  logic        accept;
  logic        res_valid;
  urp_result_t res;

  logic        out_valid_r;
  urp_result_t out_r;

  // A byte is taken whenever the output register is free or being drained.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  urp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= accept && res_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_field_kind   = out_r.kind;
  assign out_field_value  = out_r.value;
  assign out_record_index = out_r.index;
  assign out_record_done  = out_r.done;
  assign out_import_end   = out_r.import_end;
  assign out_import_ok    = out_r.import_ok;

  // The input only stalls behind a held result.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  // An accepted last byte always yields an end-of-import word next cycle.
  a_last_gives_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> (out_valid && out_import_end))
    else $error("last byte produced no end-of-import word");

  // A word without a field only answers a last byte.
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_field_kind == KIND_NONE) |-> out_import_end)
    else $error("empty result word that is not an import end");

  // A record closes only on its script length or its final script byte.
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_done) |->
      (out_field_kind == KIND_SCRIPT_LEN || out_field_kind == KIND_SCRIPT_BYTE))
    else $error("record closed on an unexpected field");

  // Success is only reported together with the end of an import.
  a_ok_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_import_ok) |-> out_import_end)
    else $error("import_ok set without import_end");

endmodule

@@ verif/urp_field_checker.sv @@
// ----------------------------------------------------------------------------
// urp_field_checker: predicts and checks the parser's result words
// Watches both channels of the record stream parser. Every byte taken on the
// input channel runs through a local copy of the parse state, which queues the
// result word that byte should cause. Every word taken on the result channel
// is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module urp_field_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_field_kind,
  input  logic [63:0] out_field_value,
  input  logic [15:0] out_record_index,
  input  logic        out_record_done,
  input  logic        out_import_end,
  input  logic        out_import_ok,
  output int          fail_count,
  output int          pending_words
);
  import urp_pkg::*;

  // Local parse state.
  phase_t      phase;
  logic [3:0]  field_count;
  logic [63:0] field_acc;
  logic [15:0] records_left;
  logic [15:0] record_no;
  logic [31:0] bytes_left;
  logic [3:0]  prefix_size;
  logic        overrun;

  // Field completed by the byte being parsed.
  kind_t       word_kind;
  logic [63:0] word_value;
  logic        word_done;

  urp_result_t expected_words[$];
  int          shown_count;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    shown_count   = 0;
  end

  task parser_reset();
    phase        = PH_CNT0;
    field_count  = '0;
    field_acc    = '0;
    records_left = '0;
    record_no    = '0;
    bytes_left   = '0;
    prefix_size  = '0;
    overrun      = 1'b0;
  endtask

  task clear_field();
    field_count = '0;
    field_acc   = '0;
  endtask

  // Little-endian accumulation; the shift position repeats every 8 bytes.
  task take_field_byte(input logic [7:0] b);
    field_acc   = field_acc | ({56'd0, b} << (8 * field_count[2:0]));
    field_count = field_count + 4'd1;
  endtask

  task load_count(input logic [15:0] n);
    records_left = n;
    record_no    = '0;
    clear_field();
    if (n != 16'd0) begin
      phase = PH_HEIGHT;
    end else begin
      phase = PH_DONE;
    end
  endtask

  task close_record();
    word_done    = 1'b1;
    record_no    = record_no + 16'd1;
    records_left = records_left - 16'd1;
    clear_field();
    if (records_left != 16'd0) begin
      phase = PH_HEIGHT;
    end else begin
      phase = PH_DONE;
    end
  endtask

  // A zero-length script closes the record on the length word itself.
  task open_script(input logic [31:0] n);
    word_kind  = KIND_SCRIPT_LEN;
    word_value = {32'd0, n};
    bytes_left = n;
    clear_field();
    if (n == 32'd0) begin
      close_record();
    end else begin
      phase = PH_SCRIPT;
    end
  endtask

  // Advance the parse state by one byte and queue the word it causes.
  task parse_byte(input logic [7:0] b, input logic last);
    logic [15:0] idx;
    urp_result_t w;
    idx        = record_no;
    word_kind  = KIND_NONE;
    word_value = '0;
    word_done  = 1'b0;
    case (phase)
      PH_CNT0: begin
        if (b == CS_PREFIX16) begin
          prefix_size = CS_SIZE16;
          clear_field();
          phase = PH_CNTX;
        end else begin
          load_count({8'd0, b});
        end
      end
      PH_CNTX: begin
        take_field_byte(b);
        if (field_count >= prefix_size) begin
          load_count(field_acc[15:0]);
        end
      end
      PH_HEIGHT: begin
        take_field_byte(b);
        if (field_count >= HEIGHT_BYTES) begin
          word_kind  = KIND_HEIGHT;
          word_value = field_acc;
          clear_field();
          bytes_left = HASH_BYTES;
          phase      = PH_HASH;
        end
      end
      PH_HASH: begin
        word_kind  = KIND_HASH_BYTE;
        word_value = {56'd0, b};
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          clear_field();
          phase = PH_VOUT;
        end
      end
      PH_VOUT: begin
        take_field_byte(b);
        if (field_count >= VOUT_BYTES) begin
          word_kind  = KIND_VOUT;
          word_value = field_acc;
          clear_field();
          phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        take_field_byte(b);
        if (field_count >= VALUE_BYTES) begin
          word_kind  = KIND_VALUE;
          word_value = field_acc;
          clear_field();
          phase = PH_LEN0;
        end
      end
      PH_LEN0: begin
        if (b >= CS_PREFIX16) begin
          if (b == CS_PREFIX16) begin
            prefix_size = CS_SIZE16;
          end else if (b == CS_PREFIX32) begin
            prefix_size = CS_SIZE32;
          end else begin
            prefix_size = CS_SIZE64;
          end
          clear_field();
          phase = PH_LENX;
        end else begin
          open_script({24'd0, b});
        end
      end
      PH_LENX: begin
        take_field_byte(b);
        if (field_count >= prefix_size) begin
          open_script(field_acc[31:0]);
        end
      end
      PH_SCRIPT: begin
        word_kind  = KIND_SCRIPT_BYTE;
        word_value = {56'd0, b};
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          close_record();
        end
      end
      default: begin
        // Bytes past the end of the list spoil the import.
        overrun = 1'b1;
      end
    endcase

    if (word_kind == KIND_NONE) begin
      idx = '0;
    end
    if (last || word_kind != KIND_NONE) begin
      w.kind       = word_kind;
      w.value      = word_value;
      w.index      = idx;
      w.done       = word_done;
      w.import_end = last;
      w.import_ok  = last && phase == PH_DONE && !overrun;
      expected_words = {expected_words, w};
    end
    if (last) begin
      parser_reset();
    end
  endtask

  task note_failure(input string msg);
    fail_count = fail_count + 1;
    if (shown_count < 10) begin
      shown_count = shown_count + 1;
      $display("%s", msg);
    end
  endtask

  // Compare one accepted result word with the oldest expectation.
  task check_word();
    urp_result_t w;
    if (expected_words.size() == 0) begin
      note_failure($sformatf(
        "unexpected word: kind %0d value %h index %0d done %0d end %0d ok %0d",
        out_field_kind, out_field_value, out_record_index,
        out_record_done, out_import_end, out_import_ok));
    end else begin
      w = expected_words.pop_front();
      if (out_field_kind !== w.kind || out_field_value !== w.value ||
          out_record_index !== w.index || out_record_done !== w.done ||
          out_import_end !== w.import_end || out_import_ok !== w.import_ok) begin
        note_failure($sformatf(
          "word mismatch: expected kind %0d value %h index %0d done %0d end %0d ok %0d",
          w.kind, w.value, w.index, w.done, w.import_end, w.import_ok));
        if (shown_count <= 10 && fail_count <= 10) begin
          $display("              got      kind %0d value %h index %0d done %0d end %0d ok %0d",
                   out_field_kind, out_field_value, out_record_index,
                   out_record_done, out_import_end, out_import_ok);
        end
      end
    end
  endtask

  // Results are checked before the byte of the same edge is parsed; since each
  // word is registered, a byte's word can never leave on its own edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      parser_reset();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_word();
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_data_byte, in_last_byte);
      end
    end
    pending_words = expected_words.size();
  end

endmodule

@@ verif/utxo_record_stream_parser_test.sv @@
// ----------------------------------------------------------------------------
// utxo_record_stream_parser_test: testbench for the record stream parser
// Feeds short directed imports (zero count, truncated counts, trailing bytes,
// cut-off records) and then random imports, mostly well-formed record lists
// with random content, some with trailing bytes, cut short, with an oversized
// script length, or plain noise. Sender gaps and receiver stalls rotate
// through several patterns; a separate checker predicts every result word.
// ----------------------------------------------------------------------------
module utxo_record_stream_parser_test;
  import urp_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int STUCK_LIMIT = 4000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_field_kind;
  logic [63:0] out_field_value;
  logic [15:0] out_record_index;
  logic        out_record_done;
  logic        out_import_end;
  logic        out_import_ok;

  int          fail_count;
  int          pending_words;
  int          sent_count;
  int          stuck_cycles;
  idle_mode_t  idle_mode;
  logic [7:0]  import_bytes[$];

  utxo_record_stream_parser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field_kind   (out_field_kind),
    .out_field_value  (out_field_value),
    .out_record_index (out_record_index),
    .out_record_done  (out_record_done),
    .out_import_end   (out_import_end),
    .out_import_ok    (out_import_ok)
  );

  urp_field_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field_kind   (out_field_kind),
    .out_field_value  (out_field_value),
    .out_record_index (out_record_index),
    .out_record_done  (out_record_done),
    .out_import_end   (out_import_end),
    .out_import_ok    (out_import_ok),
    .fail_count       (fail_count),
    .pending_words    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stalls according to the current idling pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_stall <= ($urandom_range(99) < 84);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without a word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("utxo_record_stream_parser_test NOT OK");
        $finish;
      end
    end
  end

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) begin
      return $urandom_range(99) < 84;
    end else if (idle_mode == IDLE_BOTH) begin
      return $urandom_range(99) < 10;
    end
    return 1'b0;
  endfunction

  // Offer one byte and hold it until the parser takes it.
  task send_word(input logic [7:0] b, input logic last);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent_count = sent_count + 1;
  endtask

  task send_import();
    for (int i = 0; i < import_bytes.size(); i++) begin
      send_word(import_bytes[i], i == import_bytes.size() - 1);
    end
  endtask

  // Append one byte to the import under construction.
  task add_byte(input logic [7:0] b);
    import_bytes = {import_bytes, b};
  endtask

  task push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) begin
      add_byte(v[8*i +: 8]);
    end
  endtask

  task push_random(input int n);
    for (int i = 0; i < n; i++) begin
      add_byte(8'($urandom));
    end
  endtask

  // Script length in any of the compact-size forms the length allows.
  task push_length(input logic [31:0] len);
    int form;
    if (len < 32'(CS_PREFIX16) && $urandom_range(1) == 0) begin
      form = 0;
    end else if (len < 32'h10000) begin
      form = $urandom_range(1, 3);
    end else begin
      form = $urandom_range(2, 3);
    end
    case (form)
      0: add_byte(len[7:0]);
      1: begin
        add_byte(CS_PREFIX16);
        push_le({48'd0, len[15:0]}, 2);
      end
      2: begin
        add_byte(CS_PREFIX32);
        push_le({32'd0, len}, 4);
      end
      default: begin
        // Upper half is dropped by the parser, so fill it with noise.
        add_byte(CS_PREFIX64);
        push_le({32'($urandom), len}, 8);
      end
    endcase
  endtask

  // Well-formed record list; an oversized tail leaves the last script open.
  task build_list(input bit oversized_tail);
    int n;
    int r;
    logic [31:0] len;
    r = $urandom_range(9);
    n = (r == 0) ? 0 : (r <= 5) ? 1 : (r <= 8) ? 2 : 3;
    if ($urandom_range(3) == 0) begin
      add_byte(CS_PREFIX16);
      push_le(64'(n), 2);
    end else begin
      add_byte(8'(n));
    end
    for (int k = 0; k < n; k++) begin
      push_le(64'($urandom), 4);
      push_random(32);
      push_le(64'($urandom), 4);
      push_le({32'($urandom), 32'($urandom)}, 8);
      if (oversized_tail && k == n - 1) begin
        len = 32'($urandom) | 32'h0001_0000;
        push_length(len);
        push_random($urandom_range(0, 5));
      end else begin
        r = $urandom_range(19);
        if (r == 0) begin
          len = 32'd0;
        end else if (r == 1) begin
          len = $urandom_range(253, 300);
        end else begin
          len = $urandom_range(1, 8);
        end
        push_length(len);
        push_random(int'(len));
      end
    end
  endtask

  initial begin
    int import_no;
    int r;
    int keep;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'd0;
    in_last_byte <= 1'b0;
    idle_mode    = IDLE_NONE;
    sent_count   = 0;
    import_no    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Zero count, lone prefix and count bytes, truncated count.
    send_word(8'h00, 1'b1);
    send_word(CS_PREFIX64, 1'b1);
    send_word(CS_PREFIX32, 1'b1);
    send_word(CS_PREFIX16, 1'b1);
    // Zero count in the two-byte form, then a large count with its list cut short.
    send_word(CS_PREFIX16, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(CS_PREFIX16, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    // Trailing bytes after an empty list.
    send_word(8'h00, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b1);
    // Height completes on the last byte of a truncated import.
    send_word(8'h01, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);

    // Random imports, idling pattern rotating from one import to the next.
    while (sent_count < ITEM_TARGET) begin
      idle_mode = idle_mode_t'(import_no % 4);
      import_no = import_no + 1;
      import_bytes.delete();
      r = $urandom_range(99);
      if (r < 70) begin
        build_list(1'b0);
      end else if (r < 82) begin
        build_list(1'b0);
        push_random($urandom_range(1, 3));
      end else if (r < 90) begin
        build_list(1'b0);
        if (import_bytes.size() > 1) begin
          keep = $urandom_range(1, import_bytes.size() - 1);
          while (import_bytes.size() > keep) begin
            void'(import_bytes.pop_back());
          end
        end
      end else if (r < 95) begin
        build_list(1'b1);
      end else begin
        push_random($urandom_range(1, 6));
      end
      send_import();
    end
    in_valid <= 1'b0;

    // Drain the outstanding words, then give stray words time to show up.
    @(negedge clk);
    while (pending_words != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("utxo_record_stream_parser_test OK");
    end else begin
      $display("utxo_record_stream_parser_test NOT OK");
    end
    $finish;
  end

endmodule

@@ utxo_record_stream_parser.f @@
src/urp_pkg.sv
src/urp_core.sv
src/utxo_record_stream_parser.sv
verif/urp_field_checker.sv
verif/utxo_record_stream_parser_test.sv
